// ===== hw/rtl/first_best_fit_block_allocator_assert.svh =====
// Concurrent assertion macros, empty for synthesis
`ifndef FIRST_BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define FBFA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FBFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FBFA_ASSERT_SAME(lbl, ante, cons)
`define FBFA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/fbfa_pkg.sv =====
package fbfa_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 8;

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int SIZE_W = 21;
  localparam int OFF_W  = 20;
  localparam int CFG_W  = 21;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] HEAP_CEIL  = SIZE_W'(1 << OFF_W);
  localparam logic [OFF_W-1:0]  OFFSET_MAX = {OFF_W{1'b1}};

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_REUSE    = 2'd0,
    ST_GROW     = 2'd1,
    ST_NO_ROOM  = 2'd2,
    ST_BAD_ADDR = 2'd3
  } status_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

// ===== hw/rtl/fbfa_ctrl.sv =====
module fbfa_ctrl import fbfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready  = !rst;
        cmd.start = s_tvalid && !rst;
        if (s_tvalid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.out_busy) begin
          cmd.decide = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fbfa_datapath.sv =====
module fbfa_datapath import fbfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 in_op,
  input  logic [OFF_W-1:0]     in_req,
  input  logic [OFF_W-1:0]     in_addr,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OFF_W-1:0]     out_off,
  output status_t              out_status
);

  entry_t mem [MAX_BLOCKS];
  entry_t rd_q;

  logic              fit_mode;
  logic [SIZE_W-1:0] heap_limit;
  logic [CNT_W-1:0]  count;
  logic [SIZE_W-1:0] heap_used;

  logic              op_r;
  logic [SIZE_W-1:0] total;
  logic [OFF_W-1:0]  addr_r;
  logic [SIZE_W-1:0] limit_r;
  logic [CNT_W-1:0]  iss;
  logic              rd_vld;
  logic [IDX_W-1:0]  proc_idx;
  logic [SIZE_W-1:0] off;
  logic              found;
  logic [IDX_W-1:0]  pick;
  logic [SIZE_W-1:0] pick_off;
  logic [SIZE_W-1:0] pick_size;
  logic              grow_ok;

  logic              rd_en;
  logic              hit_alloc;
  logic              better;
  logic              hit_free;
  logic              take;
  logic              grow;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;

  assign rd_en     = cmd.scan && (iss < count);
  assign hit_alloc = rd_q.free && (rd_q.size >= total);
  assign better    = !found || (fit_mode && (rd_q.size < pick_size));
  assign hit_free  = ({1'b0, off} + (SIZE_W+1)'(HEADER_BYTES)) == {2'b00, addr_r};
  assign take      = rd_vld && ((op_r == OP_FREE) ? (hit_free && !found)
                                                  : (hit_alloc && better));
  assign grow      = (op_r == OP_ALLOC) && !found && grow_ok;
  assign mem_we    = cmd.decide && (found || grow);
  assign mem_waddr = found ? pick : count[IDX_W-1:0];
  assign mem_wdata = found ? entry_t'{free: (op_r == OP_FREE), size: pick_size}
                           : entry_t'{free: 1'b0, size: total};

  assign sts.scan_done = (iss == count) && !rd_vld;
  assign sts.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= mem[iss[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode   <= 1'b0;
      heap_limit <= HEAP_CEIL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_MODE:   fit_mode   <= cfg_data[0];
        REG_HEAP_LIMIT: heap_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      heap_used <= '0;
    end else if (cmd.decide && grow) begin
      count     <= count + CNT_W'(1);
      heap_used <= heap_used + total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss    <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.start) begin
      iss    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (rd_en) begin
        iss <= iss + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= in_op;
      total   <= {1'b0, in_req} + SIZE_W'(HEADER_BYTES);
      addr_r  <= in_addr;
      limit_r <= (heap_limit > HEAP_CEIL) ? HEAP_CEIL : heap_limit;
      off     <= '0;
      found   <= 1'b0;
    end else begin
      if (rd_en) begin
        proc_idx <= iss[IDX_W-1:0];
      end
      if (rd_vld) begin
        off <= off + rd_q.size;
      end
      if (take) begin
        found     <= 1'b1;
        pick      <= proc_idx;
        pick_off  <= off;
        pick_size <= rd_q.size;
      end
    end
    grow_ok <= (count < CNT_W'(MAX_BLOCKS)) && (total <= limit_r)
            && (({1'b0, heap_used} + {1'b0, total}) <= {1'b0, limit_r})
            && (({1'b0, heap_used} + (SIZE_W+1)'(HEADER_BYTES))
                <= (SIZE_W+1)'(OFFSET_MAX));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.decide) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      if (op_r == OP_FREE) begin
        out_off    <= found ? addr_r : '0;
        out_status <= found ? ST_REUSE : ST_BAD_ADDR;
      end else if (found) begin
        out_off    <= OFF_W'(pick_off + SIZE_W'(HEADER_BYTES));
        out_status <= ST_REUSE;
      end else if (grow_ok) begin
        out_off    <= OFF_W'(heap_used + SIZE_W'(HEADER_BYTES));
        out_status <= ST_GROW;
      end else begin
        out_off    <= '0;
        out_status <= ST_NO_ROOM;
      end
    end
  end

endmodule

// ===== hw/rtl/first_best_fit_block_allocator.sv =====
// Items are handled one at a time: the next is accepted only once the current one is decided,
// after a scan of the block table through its single read port, one entry per cycle.
// Reset (rst, synchronous): empty table, zero heap, first fit, limit 1048576.
// A result waiting on m_tready does not block acceptance of the next item.
`include "first_best_fit_block_allocator_assert.svh"

module first_best_fit_block_allocator import fbfa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // request_size[19:0], release_offset[39:20]
  input  logic [0:0]           s_tuser,   // operation[0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // payload_offset[19:0], zero fill[23:20]
  output logic [1:0]           m_tuser,   // status[1:0]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t             cmd;
  sts_t             sts;
  logic [OFF_W-1:0] out_off;
  status_t          out_status;
  logic             err_status;

  fbfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbfa_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (s_tuser[0]),
    .in_req     (s_tdata[19:0]),
    .in_addr    (s_tdata[39:20]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_off    (out_off),
    .out_status (out_status)
  );

  assign m_tdata    = {4'b0000, out_off};
  assign m_tuser    = out_status;
  assign err_status = (out_status == ST_NO_ROOM) || (out_status == ST_BAD_ADDR);

  `FBFA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `FBFA_ASSERT_SAME(a_decide_after_scan, cmd.decide, sts.scan_done && !sts.out_busy)
  `FBFA_ASSERT_SAME(a_error_zero_offset, m_tvalid && err_status, m_tdata == 24'd0)

endmodule
